/* rtl/core/http_request_parser_macros.svh */
// ----------------------------------------------------------------------------
// http_request_parser_macros
// assertion helpers for the request parser
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_PARSER_MACROS_SVH
`define HTTP_REQUEST_PARSER_MACROS_SVH

// condition must never hold outside reset
`define HRP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define HRP_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define HRP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// hrp_pkg
// types, constants and per-byte step functions of the request parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

  localparam int LENGTH_BITS = 64;

  localparam logic [2:0] PH_REQ   = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_DONE  = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  localparam logic [3:0] CL_METHOD = 4'd0;
  localparam logic [3:0] CL_SPACE  = 4'd1;
  localparam logic [3:0] CL_URI    = 4'd2;
  localparam logic [3:0] CL_VER    = 4'd3;
  localparam logic [3:0] CL_NAME   = 4'd4;
  localparam logic [3:0] CL_COLON  = 4'd5;
  localparam logic [3:0] CL_VALUE  = 4'd6;
  localparam logic [3:0] CL_TERM   = 4'd7;
  localparam logic [3:0] CL_BODY   = 4'd8;
  localparam logic [3:0] CL_UNCONS = 4'd9;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [2:0] DG_LEAD  = 3'd0;
  localparam logic [2:0] DG_PLUS  = 3'd1;
  localparam logic [2:0] DG_MINUS = 3'd2;
  localparam logic [2:0] DG_POS   = 3'd3;
  localparam logic [2:0] DG_NEG   = 3'd4;
  localparam logic [2:0] DG_POSST = 3'd5;
  localparam logic [2:0] DG_NEGST = 3'd6;
  localparam logic [2:0] DG_BAD   = 3'd7;

  localparam logic [1:0] LP_FIRST = 2'd0;
  localparam logic [1:0] LP_SECOND = 2'd1;
  localparam logic [1:0] LP_THIRD = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam int NUM_METH = 9;
  localparam logic [63:0] METH_TEXT [NUM_METH] = '{
    64'("GET"), 64'("POST"), 64'("PUT"), 64'("DELETE"), 64'("HEAD"),
    64'("OPTIONS"), 64'("PATCH"), 64'("TRACE"), 64'("CONNECT")};
  localparam logic [3:0] METH_LEN [NUM_METH] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7};
  localparam logic [111:0] CL_TEXT = "content-length";
  localparam logic [3:0] CL_LEN = 4'd14;

  typedef struct packed {
    logic [2:0]             phase;
    logic [1:0]             line_part;
    logic [NUM_METH-1:0]    method_match;
    logic [3:0]             token_pos;
    logic                   name_match;
    logic [2:0]             digit_state;
    logic [LENGTH_BITS-1:0] number_accum;
    logic [LENGTH_BITS-1:0] expected_length;
    logic [LENGTH_BITS-1:0] body_count;
    logic [3:0]             method_found;
  } hrp_state_t;

  typedef struct packed {
    hrp_state_t st;
    logic [7:0] ob;
    logic [3:0] cls;
  } hrp_db_t;

  typedef struct packed {
    logic [7:0]  byte_v;
    logic [3:0]  cls;
    logic        consumed;
    logic [1:0]  status;
    logic [3:0]  method_code;
    logic [63:0] content_length;
    logic        run_last;
    logic        chunk_last;
  } hrp_res_t;

  function automatic hrp_state_t clear_line(hrp_state_t s);
    hrp_state_t r;
    r = s;
    r.line_part = LP_FIRST;
    r.token_pos = 4'd0;
    r.name_match = 1'b1;
    r.digit_state = DG_LEAD;
    r.number_accum = '0;
    return r;
  endfunction

  function automatic hrp_state_t reset_state();
    hrp_state_t r;
    r = '0;
    r.phase = PH_REQ;
    r.method_match = '1;
    return clear_line(r);
  endfunction

  function automatic logic [1:0] status_of(logic [2:0] ph);
    logic [1:0] r;
    r = (ph == PH_DONE) ? ST_DONE : ((ph == PH_ERR) ? ST_ERR : ST_BUSY);
    return r;
  endfunction

  function automatic hrp_state_t digit_step(hrp_state_t s, logic [7:0] c);
    hrp_state_t r;
    logic dig;
    logic do_acc;
    logic [LENGTH_BITS+3:0] wide;
    r = s;
    dig = (c >= 8'h30) && (c <= 8'h39);
    do_acc = 1'b0;
    wide = {4'd0, s.number_accum};
    case (s.digit_state)
      DG_LEAD: begin
        if (c == CH_SP || c == CH_HT || c == CH_VT || c == CH_FF || c == CH_CR) begin
          r.digit_state = DG_LEAD;
        end else if (c == CH_PLUS) begin
          r.digit_state = DG_PLUS;
        end else if (c == CH_MINUS) begin
          r.digit_state = DG_MINUS;
        end else if (!dig) begin
          r.digit_state = DG_BAD;
        end else begin
          r.digit_state = DG_POS;
          do_acc = 1'b1;
        end
      end
      DG_PLUS, DG_MINUS: begin
        if (!dig) begin
          r.digit_state = DG_BAD;
        end else begin
          r.digit_state = (s.digit_state == DG_PLUS) ? DG_POS : DG_NEG;
          do_acc = 1'b1;
        end
      end
      DG_POS, DG_NEG: begin
        if (!dig) begin
          r.digit_state = s.digit_state + 3'd2;
        end else begin
          do_acc = 1'b1;
        end
      end
      default: r.digit_state = s.digit_state;
    endcase
    if (do_acc) begin
      wide = (wide << 3) + (wide << 1) + (LENGTH_BITS+4)'(c - 8'h30);
      if (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
        r.digit_state = DG_BAD;
      end else begin
        r.number_accum = wide[LENGTH_BITS-1:0];
      end
    end
    return r;
  endfunction

  function automatic hrp_db_t data_byte(hrp_state_t s, logic [7:0] c);
    hrp_db_t r;
    logic found;
    logic [7:0] lc;
    r.st = s;
    r.ob = c;
    r.cls = CL_URI;
    found = 1'b0;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    if (s.phase == PH_REQ) begin
      if (s.line_part == LP_FIRST) begin
        if (c == CH_SP) begin
          r.st.method_found = 4'd0;
          for (int i = 0; i < NUM_METH; i++) begin
            if (!found && s.method_match[i] && METH_LEN[i] == s.token_pos) begin
              r.st.method_found = 4'(i + 1);
              found = 1'b1;
            end
          end
          r.st.line_part = LP_SECOND;
          r.cls = CL_SPACE;
        end else begin
          for (int i = 0; i < NUM_METH; i++) begin
            if (s.token_pos >= METH_LEN[i] ||
                METH_TEXT[i][8*(int'(METH_LEN[i]) - 1 - int'(s.token_pos)) +: 8] != c) begin
              r.st.method_match[i] = 1'b0;
            end
          end
          if (s.token_pos != 4'd15) r.st.token_pos = s.token_pos + 4'd1;
          r.cls = CL_METHOD;
        end
      end else if (s.line_part == LP_SECOND) begin
        if (c == CH_SP) begin
          r.st.line_part = LP_THIRD;
          r.cls = CL_SPACE;
        end else begin
          r.cls = CL_URI;
        end
      end else begin
        r.cls = CL_VER;
      end
    end else if (s.line_part == LP_FIRST) begin
      if (c == CH_COLON) begin
        r.st.name_match = s.name_match && (s.token_pos == CL_LEN);
        r.st.line_part = LP_SECOND;
        r.cls = CL_COLON;
      end else begin
        if (s.token_pos >= CL_LEN ||
            CL_TEXT[8*(13 - int'(s.token_pos)) +: 8] != lc) begin
          r.st.name_match = 1'b0;
        end
        if (s.token_pos != 4'd15) r.st.token_pos = s.token_pos + 4'd1;
        r.ob = lc;
        r.cls = CL_NAME;
      end
    end else begin
      if (s.name_match) r.st = digit_step(s, c);
      r.cls = CL_VALUE;
    end
    return r;
  endfunction

  function automatic hrp_state_t end_line(hrp_state_t s);
    hrp_state_t r;
    r = s;
    if (s.phase == PH_REQ) begin
      r.phase = (s.line_part == LP_THIRD && s.method_found != 4'd0) ? PH_HDR : PH_ERR;
    end else if (s.line_part == LP_FIRST && s.token_pos == 4'd0) begin
      r.phase = (s.expected_length != '0) ? PH_BODY : PH_DONE;
    end else if (s.line_part == LP_FIRST) begin
      r.phase = PH_ERR;
    end else if (s.name_match) begin
      if (s.digit_state == DG_POS || s.digit_state == DG_POSST) begin
        r.expected_length = s.number_accum;
      end else if (s.digit_state == DG_NEG || s.digit_state == DG_NEGST) begin
        r.expected_length = '0 - s.number_accum;
      end else begin
        r.phase = PH_ERR;
      end
    end
    return clear_line(r);
  endfunction

  function automatic hrp_res_t mk_res(hrp_state_t s, logic [7:0] b, logic [3:0] cls,
                                      logic cons);
    hrp_res_t r;
    r.byte_v = b;
    r.cls = cls;
    r.consumed = cons;
    r.status = status_of(s.phase);
    r.method_code = s.method_found;
    r.content_length = 64'(s.expected_length);
    r.run_last = 1'b0;
    r.chunk_last = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/http_request_parser.sv */
// ----------------------------------------------------------------------------
// http_request_parser
// tags each byte of an http/1.1 request with its role, one byte per word
// ----------------------------------------------------------------------------
// channel | ports                   | words
// input   | in_valid / in_stall     | one request byte
// result  | out_valid / out_stall   | one tagged byte, zero to two per input
//
// an input word is taken every cycle while the 4-entry result queue has room
// for two results; each word yields zero, one or two results
// a held cr followed by any byte but another cr, without in_restart, gives two results in one word
// the result queue drains one word per cycle; out_stall backs it up
// reset (rst_n low) returns the parser to the start of a request line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_parser_macros.svh"

module http_request_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_restart,
  input  logic        in_chunk_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [3:0]  out_byte_class,
  output logic        out_consumed,
  output logic [1:0]  out_status,
  output logic [3:0]  out_method_code,
  output logic [63:0] out_content_length,
  output logic        out_run_last,
  output logic        out_chunk_last_out
);

  hrp_pkg::hrp_state_t st_r, st_nxt;
  logic                cr_r, cr_nxt;
  hrp_pkg::hrp_res_t   res_r [4];
  logic [1:0]          wr_r, rd_r;
  logic [2:0]          cnt_r;
  hrp_pkg::hrp_res_t   r0, r1;
  logic [1:0]          n_res;
  logic                push, pop;

  always_comb begin
    hrp_pkg::hrp_state_t s;
    hrp_pkg::hrp_db_t    db;
    logic                c_used;
    s = in_restart ? hrp_pkg::reset_state() : st_r;
    cr_nxt = in_restart ? 1'b0 : cr_r;
    r0 = '0;
    r1 = '0;
    n_res = 2'd0;
    c_used = 1'b0;
    db = '0;
    if (s.phase >= hrp_pkg::PH_DONE) begin
      r0 = hrp_pkg::mk_res(s, in_byte, hrp_pkg::CL_UNCONS, 1'b0);
      n_res = 2'd1;
    end else if (s.phase == hrp_pkg::PH_BODY) begin
      s.body_count = s.body_count + 1'b1;
      if (s.body_count == s.expected_length) s.phase = hrp_pkg::PH_DONE;
      r0 = hrp_pkg::mk_res(s, in_byte, hrp_pkg::CL_BODY, 1'b1);
      n_res = 2'd1;
    end else begin
      if (cr_nxt) begin
        cr_nxt = 1'b0;
        if (in_byte == hrp_pkg::CH_LF) begin
          r0 = hrp_pkg::mk_res(s, hrp_pkg::CH_CR, hrp_pkg::CL_TERM, 1'b1);
          s = hrp_pkg::end_line(s);
          r1 = hrp_pkg::mk_res(s, in_byte, hrp_pkg::CL_TERM, 1'b1);
          n_res = 2'd2;
          c_used = 1'b1;
        end else begin
          db = hrp_pkg::data_byte(s, hrp_pkg::CH_CR);
          s = db.st;
          r0 = hrp_pkg::mk_res(s, db.ob, db.cls, 1'b1);
          n_res = 2'd1;
        end
      end
      if (!c_used) begin
        if (in_byte == hrp_pkg::CH_LF) begin
          s = hrp_pkg::end_line(s);
          r1 = hrp_pkg::mk_res(s, in_byte, hrp_pkg::CL_TERM, 1'b1);
          n_res = n_res + 2'd1;
        end else if (in_byte == hrp_pkg::CH_CR) begin
          cr_nxt = 1'b1;
        end else begin
          db = hrp_pkg::data_byte(s, in_byte);
          s = db.st;
          r1 = hrp_pkg::mk_res(s, db.ob, db.cls, 1'b1);
          n_res = n_res + 2'd1;
        end
        if (n_res == 2'd1 && in_byte != hrp_pkg::CH_CR) r0 = r1;
      end
    end
    if (n_res == 2'd1) begin
      r0.run_last = 1'b1;
      r0.chunk_last = in_chunk_last;
    end else if (n_res == 2'd2) begin
      r1.run_last = 1'b1;
      r1.chunk_last = in_chunk_last;
    end
    st_nxt = s;
  end

  assign in_stall  = (cnt_r > 3'd2);
  assign push      = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= hrp_pkg::reset_state();
      cr_r  <= 1'b0;
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) begin
        st_r <= st_nxt;
        cr_r <= cr_nxt;
        wr_r <= wr_r + n_res;
      end
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + (push ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && n_res != 2'd0) res_r[wr_r] <= r0;
    if (push && n_res == 2'd2) res_r[wr_r + 2'd1] <= r1;
  end

  assign out_byte           = res_r[rd_r].byte_v;
  assign out_byte_class     = res_r[rd_r].cls;
  assign out_consumed       = res_r[rd_r].consumed;
  assign out_status         = res_r[rd_r].status;
  assign out_method_code    = res_r[rd_r].method_code;
  assign out_content_length = res_r[rd_r].content_length;
  assign out_run_last       = res_r[rd_r].run_last;
  assign out_chunk_last_out = res_r[rd_r].chunk_last;

  `HRP_NEVER(a_cnt_range, cnt_r > 3'd4)
  `HRP_IMPL(a_after_end_one, push && !in_restart && st_r.phase >= hrp_pkg::PH_DONE,
            n_res == 2'd1 && r0.consumed == 1'b0)
  `HRP_NEXT(a_two_fill, push && n_res == 2'd2 && !pop, cnt_r == $past(cnt_r) + 3'd2)

endmodule

/* sim/tb_http_request_parser.sv */
// ----------------------------------------------------------------------------
// tb_http_request_parser
// self-checking bench: directed byte table, random request streams and byte noise,
// every result word compared against an in-bench parser model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_http_request_parser;
  import hrp_pkg::*;

  typedef struct packed {
    logic [7:0]  b;
    logic [3:0]  cls;
    logic        cons;
    logic [1:0]  st;
    logic [3:0]  meth;
    logic [63:0] clen;
    logic        last;
    logic        chunk;
  } tag_t;

  typedef struct {
    logic [7:0] b;
    logic       rs;
    logic       ck;
    logic       chk;
    logic [3:0] cls;
    logic [1:0] st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_restart = 1'b0;
  logic        in_chunk_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [3:0]  out_byte_class;
  logic        out_consumed;
  logic [1:0]  out_status;
  logic [3:0]  out_method_code;
  logic [63:0] out_content_length;
  logic        out_run_last;
  logic        out_chunk_last_out;

  http_request_parser dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [2:0]  m_phase;
  logic [1:0]  m_part;
  logic [8:0]  m_alive;
  logic [3:0]  m_pos;
  logic        m_cr;
  logic        m_nm;
  logic [2:0]  m_dg;
  logic [63:0] m_acc;
  logic [63:0] m_len;
  logic [63:0] m_body;
  logic [3:0]  m_meth;

  tag_t        tag_q[$];
  logic        typed_q[$];
  tag_t        typed_v[$];
  int          errors = 0;
  int          cycles = 0;
  bit          feeding_done = 1'b0;

  string meth_s[9] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS", "PATCH",
                       "TRACE", "CONNECT"};
  string cl_s = "content-length";

  function automatic void line_clear();
    m_part = LP_FIRST;
    m_pos = 4'd0;
    m_nm = 1'b1;
    m_dg = DG_LEAD;
    m_acc = '0;
  endfunction

  function automatic void parser_reset();
    m_phase = PH_REQ;
    m_alive = '1;
    m_cr = 1'b0;
    m_len = '0;
    m_body = '0;
    m_meth = 4'd0;
    line_clear();
  endfunction

  function automatic void push_tag(logic [7:0] b, logic [3:0] c, logic cons);
    tag_t t;
    t.b = b;
    t.cls = c;
    t.cons = cons;
    t.st = (m_phase == PH_DONE) ? ST_DONE : (m_phase == PH_ERR) ? ST_ERR : ST_BUSY;
    t.meth = m_meth;
    t.clen = m_len;
    t.last = 1'b0;
    t.chunk = 1'b0;
    tag_q.push_back(t);
  endfunction

  function automatic void number_step(logic [7:0] c);
    logic dig;
    logic [67:0] w;
    dig = c >= "0" && c <= "9";
    case (m_dg)
      DG_LEAD: begin
        if (c == CH_SP || c == CH_HT || c == CH_VT || c == CH_FF || c == CH_CR) return;
        if (c == CH_PLUS) begin m_dg = DG_PLUS; return; end
        if (c == CH_MINUS) begin m_dg = DG_MINUS; return; end
        if (!dig) begin m_dg = DG_BAD; return; end
        m_dg = DG_POS;
      end
      DG_PLUS, DG_MINUS: begin
        if (!dig) begin m_dg = DG_BAD; return; end
        m_dg = (m_dg == DG_PLUS) ? DG_POS : DG_NEG;
      end
      DG_POS, DG_NEG: begin
        if (!dig) begin m_dg = m_dg + 3'd2; return; end
      end
      default: return;
    endcase
    w = {4'd0, m_acc} * 68'd10 + 68'(c - 8'h30);
    if (w[67:64] != 4'd0) m_dg = DG_BAD;
    else m_acc = w[63:0];
  endfunction

  function automatic void tag_data(logic [7:0] c);
    logic [7:0] lc;
    if (m_phase == PH_REQ) begin
      if (m_part == LP_FIRST) begin
        if (c == CH_SP) begin
          m_meth = 4'd0;
          for (int i = 8; i >= 0; i--)
            if (m_alive[i] && meth_s[i].len() == m_pos) m_meth = 4'(i + 1);
          m_part = LP_SECOND;
          push_tag(c, CL_SPACE, 1'b1);
        end else begin
          for (int i = 0; i < 9; i++)
            if (m_pos >= meth_s[i].len() || meth_s[i][m_pos] != c) m_alive[i] = 1'b0;
          if (m_pos != 4'd15) m_pos++;
          push_tag(c, CL_METHOD, 1'b1);
        end
      end else if (m_part == LP_SECOND) begin
        if (c == CH_SP) m_part = LP_THIRD;
        push_tag(c, c == CH_SP ? CL_SPACE : CL_URI, 1'b1);
      end else begin
        push_tag(c, CL_VER, 1'b1);
      end
    end else if (m_part == LP_FIRST) begin
      if (c == CH_COLON) begin
        m_nm = m_nm && m_pos == 4'd14;
        m_part = LP_SECOND;
        push_tag(c, CL_COLON, 1'b1);
      end else begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (m_pos >= 4'd14 || cl_s[m_pos] != lc) m_nm = 1'b0;
        if (m_pos != 4'd15) m_pos++;
        push_tag(lc, CL_NAME, 1'b1);
      end
    end else begin
      if (m_nm) number_step(c);
      push_tag(c, CL_VALUE, 1'b1);
    end
  endfunction

  function automatic void line_done();
    if (m_phase == PH_REQ) begin
      m_phase = (m_part == LP_THIRD && m_meth != 4'd0) ? PH_HDR : PH_ERR;
    end else if (m_part == LP_FIRST && m_pos == 4'd0) begin
      m_phase = (m_len != '0) ? PH_BODY : PH_DONE;
    end else if (m_part == LP_FIRST) begin
      m_phase = PH_ERR;
    end else if (m_nm) begin
      if (m_dg == DG_POS || m_dg == DG_POSST) m_len = m_acc;
      else if (m_dg == DG_NEG || m_dg == DG_NEGST) m_len = '0 - m_acc;
      else m_phase = PH_ERR;
    end
    line_clear();
  endfunction

  // returns number of tags queued for this word
  function automatic int predict_tags(logic [7:0] c, logic rs, logic ck);
    int n0;
    bit lf_used;
    n0 = tag_q.size();
    lf_used = 1'b0;
    if (rs) parser_reset();
    if (m_phase >= PH_DONE) begin
      push_tag(c, CL_UNCONS, 1'b0);
    end else if (m_phase == PH_BODY) begin
      m_body++;
      if (m_body == m_len) m_phase = PH_DONE;
      push_tag(c, CL_BODY, 1'b1);
    end else begin
      if (m_cr) begin
        m_cr = 1'b0;
        if (c == CH_LF) begin
          push_tag(CH_CR, CL_TERM, 1'b1);
          line_done();
          push_tag(c, CL_TERM, 1'b1);
          lf_used = 1'b1;
        end else begin
          tag_data(CH_CR);
        end
      end
      if (!lf_used) begin
        if (c == CH_LF) begin
          line_done();
          push_tag(c, CL_TERM, 1'b1);
        end else if (c == CH_CR) begin
          m_cr = 1'b1;
        end else begin
          tag_data(c);
        end
      end
    end
    if (tag_q.size() > n0) begin
      tag_q[$].last = 1'b1;
      tag_q[$].chunk = ck;
    end
    return tag_q.size() - n0;
  endfunction

  row_t rows[$];

  task automatic add_row(logic [7:0] b, logic rs, logic ck, logic chk = 1'b0,
                         logic [3:0] cls = 4'd0, logic [1:0] st = 2'd0);
    row_t r;
    r.b = b; r.rs = rs; r.ck = ck; r.chk = chk; r.cls = cls; r.st = st;
    rows.push_back(r);
  endtask

  task automatic add_text(string s, bit rs_first);
    for (int i = 0; i < s.len(); i++)
      add_row(s[i], rs_first && i == 0, 1'($urandom_range(0, 1)));
  endtask

  function automatic string rand_token(int lo, int hi);
    string s;
    int n;
    s = "";
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(33, 126)))};
    return s;
  endfunction

  function automatic string eol();
    string e;
    if ($urandom_range(0, 3) == 0) e = "\n";
    else e = "\r\n";
    return e;
  endfunction

  // one random request, mostly well formed
  task automatic add_request();
    string s, v, nm, sp, tl;
    int nh, blen, k;
    k = $urandom_range(0, 19);
    s = (k == 0) ? rand_token(1, 8) : meth_s[$urandom_range(0, 8)];
    s = {s, " /", rand_token(0, 6)};
    if (k != 1) s = {s, " HTTP/1.1"};
    s = {s, eol()};
    nh = $urandom_range(0, 3);
    blen = 0;
    for (int h = 0; h < nh; h++) begin
      if ($urandom_range(0, 2) == 0) begin
        blen = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
          0: v = "-1";
          1: v = "+";
          2: v = "99999999999999999999";
          3: v = "18446744073709551615";
          4: v = "abc";
          default: v = $sformatf("%0d", blen);
        endcase
        nm = "content-LENGTH:";
        if ($urandom_range(0, 1) != 0) nm = "Content-Length:";
        sp = "\t";
        if ($urandom_range(0, 1) != 0) sp = " ";
        tl = "";
        if ($urandom_range(0, 1) != 0) tl = " x";
        s = {s, nm, sp, v, tl, eol()};
      end else begin
        s = {s, rand_token(1, 10)};
        if ($urandom_range(0, 15) != 0) s = {s, ":", rand_token(0, 8)};
        s = {s, eol()};
      end
    end
    s = {s, eol()};
    for (int i = 0; i < blen; i++) s = {s, string'(byte'($urandom_range(0, 255)))};
    add_text(s, 1'b1);
    // trailing bytes follow the request; they go unconsumed once it has completed
    for (int i = $urandom_range(0, 2); i > 0; i--)
      add_row(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // sender
  initial begin
    int gap;
    row_t r;
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    parser_reset();
    // directed part: reset, error codes, extremes
    add_row("X", 1'b0, 1'b1, 1'b1, CL_METHOD, ST_BUSY);
    add_row(CH_SP, 1'b0, 1'b0, 1'b1, CL_SPACE, ST_BUSY);
    add_row("/", 1'b0, 1'b0, 1'b1, CL_URI, ST_BUSY);
    add_row(CH_SP, 1'b0, 1'b0, 1'b1, CL_SPACE, ST_BUSY);
    add_row("V", 1'b0, 1'b0, 1'b1, CL_VER, ST_BUSY);
    add_row(CH_LF, 1'b0, 1'b1, 1'b1, CL_TERM, ST_ERR);
    add_row(8'hff, 1'b0, 1'b0, 1'b1, CL_UNCONS, ST_ERR);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, CL_UNCONS, ST_ERR);
    add_text("GET / H\r\nA\rB\n", 1'b1);
    add_text("GET / H\nA:\r\r\rB\r\n\n", 1'b1);
    add_text("POST /\r\n", 1'b1);
    add_text("PUT a b\nContent-Length: 18446744073709551615\nx:-\r\n\r\n", 1'b1);
    foreach (meth_s[i]) add_text({meth_s[i], " / V\n\n"}, 1'b1);
    add_text("HEAD / V\ncontent-length: -2\n\n\xff\x00", 1'b1);
    add_text("GET / V\ncontent-length:\n\n", 1'b1);
    add_text("GET / V\ncontent-length: +12a\r\n\n", 1'b1);
    add_text("GET / V\nnocolon\n", 1'b1);
    while (rows.size() < 1900) add_request();
    // random byte noise with restarts
    for (int i = 0; i < 60; i++)
      add_row(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
              1'($urandom_range(0, 1)));
    foreach (rows[i]) begin
      r = rows[i];
      gap = $urandom_range(0, 3);
      if (i > 300 && i < 700) gap = 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte <= r.b;
      in_restart <= r.rs;
      in_chunk_last <= r.ck;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      n = predict_tags(r.b, r.rs, r.ck);
      for (int k = 0; k < n; k++) begin
        typed_q.push_back(r.chk && k == n - 1);
        typed_v.push_back(tag_t'{b: r.b, cls: r.cls, st: r.st, default: '0});
      end
      @(negedge clk);
    end
    in_valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // receiver stalls, with one long hold-off
  initial begin
    int w;
    out_stall <= 1'b0;
    repeat (400) @(negedge clk);
    out_stall <= 1'b1;
    repeat (60) @(negedge clk);
    forever begin
      w = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) w = 0;
      out_stall <= (w != 0);
      repeat (w) @(negedge clk);
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // result checking
  always @(posedge clk) begin
    tag_t got, exp;
    logic  typed;
    tag_t  tv;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte, out_byte_class, out_consumed, out_status, out_method_code,
              out_content_length, out_run_last, out_chunk_last_out};
      if (tag_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
      end else begin
        exp = tag_q.pop_front();
        typed = typed_q.pop_front();
        tv = typed_v.pop_front();
        if (got != exp || (typed && (got.cls != tv.cls || got.st != tv.st))) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp, got);
        end
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (tag_q.size() != 0 && cycles < 200000) @(posedge clk);
    repeat (20) @(posedge clk);
    if (cycles >= 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (errors == 0 && tag_q.size() == 0) begin
      $display("[ OK ] regression clean");
      $finish;
    end else begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    wait (cycles >= 200000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
